[design/rhp_pkg.sv]
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants for the RTP / H.264 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

    // longest packet taken; later bytes are dropped and flagged
    localparam int unsigned MAX_PACKET_BYTES = 65535;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned HEND_W = 18;

    // fixed RTP header length in bytes
    localparam logic [POS_W-1:0]  FIXED_HDR_BYTES = POS_W'(12);
    localparam logic [HEND_W-1:0] HDR_END_RESET   = HEND_W'(12);
    localparam logic [HEND_W-1:0] HDR_END_MAX     = {HEND_W{1'b1}};

    // H.264 NAL unit types handled in the RTP payload
    localparam logic [4:0] NAL_SINGLE_FIRST = 5'd1;
    localparam logic [4:0] NAL_SINGLE_LAST  = 5'd23;
    localparam logic [4:0] NAL_STAP_A       = 5'd24;
    localparam logic [4:0] NAL_STAP_B       = 5'd25;
    localparam logic [4:0] NAL_MTAP16       = 5'd26;
    localparam logic [4:0] NAL_MTAP24       = 5'd27;
    localparam logic [4:0] NAL_FU_A         = 5'd28;
    localparam logic [4:0] NAL_FU_B         = 5'd29;

    // result status codes
    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_OVERRUN   = 4'd2,
        ST_EMPTY     = 4'd3,
        ST_FORBIDDEN = 4'd4,
        ST_STAP_A    = 4'd5,
        ST_STAP_B    = 4'd6,
        ST_MTAP16    = 4'd7,
        ST_MTAP24    = 4'd8,
        ST_FU_B      = 4'd9,
        ST_UNKNOWN   = 4'd10,
        ST_TOO_LONG  = 4'd11
    } t_status;

    // one packet byte in flight
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_xfer;

    // packet state as it stands after the current byte is taken
    typedef struct packed {
        logic [7:0]        flags;
        logic [7:0]        marker_pt;
        logic [15:0]       seq;
        logic [31:0]       ts;
        logic [31:0]       ssrc;
        logic [HEND_W-1:0] header_end;
        logic [15:0]       nal_fu;
        logic [POS_W-1:0]  count;
        logic              too_long;
    } t_pkt_view;

endpackage

`default_nettype wire

[design/rhp_in_stage.sv]
// ----------------------------------------------------------------------------
// rhp_in_stage
// Input register for packet bytes, with the forward handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_in_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rhp_pkg::t_byte_xfer i_byte,
    input  wire logic               i_res_ready,
    output logic                    o_step,
    output rhp_pkg::t_byte_xfer     o_byte
);
    import rhp_pkg::*;

    logic       r_in_valid;
    t_byte_xfer r_in;

    // a final byte moves on only when the result register can take it
    assign o_step     = r_in_valid && (!r_in.last || i_res_ready);
    assign o_in_ready = !r_in_valid || o_step;
    assign o_byte     = r_in;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_byte;
        end
    end

endmodule

`default_nettype wire

[design/rhp_capture.sv]
// ----------------------------------------------------------------------------
// rhp_capture
// Per-packet state: byte count, RTP header fields, extension length,
// header end and the first two payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_capture (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire rhp_pkg::t_byte_xfer i_byte,
    output rhp_pkg::t_pkt_view       o_view
);
    import rhp_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [7:0]        r_flags;
    logic [7:0]        r_marker_pt;
    logic [15:0]       r_seq;
    logic [31:0]       r_ts;
    logic [31:0]       r_ssrc;
    logic [15:0]       r_ext;
    logic [HEND_W-1:0] r_header_end;
    logic [15:0]       r_nal_fu;
    logic              r_too_long;

    logic [POS_W-1:0]  n_pos;
    logic [7:0]        n_flags;
    logic [7:0]        n_marker_pt;
    logic [15:0]       n_seq;
    logic [31:0]       n_ts;
    logic [31:0]       n_ssrc;
    logic [15:0]       n_ext;
    logic [HEND_W-1:0] n_header_end;
    logic [15:0]       n_nal_fu;
    logic              n_too_long;

    logic [6:0]        base;
    logic [HEND_W:0]   ext_end;
    logic [HEND_W:0]   he_plus1;
    logic              take;
    logic [7:0]        b;

    assign b = i_byte.data;

    // state after the current byte
    always_comb begin
        n_pos        = r_pos;
        n_flags      = r_flags;
        n_marker_pt  = r_marker_pt;
        n_seq        = r_seq;
        n_ts         = r_ts;
        n_ssrc       = r_ssrc;
        n_ext        = r_ext;
        n_header_end = r_header_end;
        n_nal_fu     = r_nal_fu;
        n_too_long   = r_too_long;
        take         = r_pos < POS_W'(MAX_PACKET_BYTES);
        base         = '0;
        ext_end      = '0;
        he_plus1     = {1'b0, r_header_end} + (HEND_W+1)'(1);

        if (!take) begin
            n_too_long = 1'b1;
        end else begin
            n_pos = r_pos + POS_W'(1);

            // fixed header bytes
            if (r_pos == '0) begin
                n_flags     = b;
                n_marker_pt = '0;
                n_seq       = '0;
                n_ts        = '0;
                n_ssrc      = '0;
                n_ext       = '0;
                n_nal_fu    = '0;
            end else begin
                case (r_pos) inside
                    POS_W'(1):                  n_marker_pt = b;
                    POS_W'(2):                  n_seq[15:8] = b;
                    POS_W'(3):                  n_seq[7:0]  = b;
                    POS_W'(4):                  n_ts[31:24] = b;
                    POS_W'(5):                  n_ts[23:16] = b;
                    POS_W'(6):                  n_ts[15:8]  = b;
                    POS_W'(7):                  n_ts[7:0]   = b;
                    POS_W'(8):                  n_ssrc[31:24] = b;
                    POS_W'(9):                  n_ssrc[23:16] = b;
                    POS_W'(10):                 n_ssrc[15:8]  = b;
                    POS_W'(11):                 n_ssrc[7:0]   = b;
                    default: ;
                endcase
            end

            // end of CSRC list
            base = 7'd12 + {1'b0, n_flags[3:0], 2'b00};
            if (r_pos == '0) begin
                n_header_end = HEND_W'(base) + (n_flags[4] ? HEND_W'(4) : '0);
            end

            // extension length word, then its end
            if (n_flags[4] && (r_pos == POS_W'(base) + POS_W'(2) ||
                               r_pos == POS_W'(base) + POS_W'(3))) begin
                n_ext = {r_ext[7:0], b};
                if (r_pos == POS_W'(base) + POS_W'(3)) begin
                    ext_end = (HEND_W+1)'(base) + (HEND_W+1)'(4)
                            + {1'b0, n_ext, 2'b00};
                    n_header_end = ext_end[HEND_W] ? HDR_END_MAX : ext_end[HEND_W-1:0];
                end
            end

            // first two payload bytes
            if (r_pos >= FIXED_HDR_BYTES) begin
                if ({2'b00, r_pos} == r_header_end) begin
                    n_nal_fu[15:8] = b;
                end else if ({3'b000, r_pos} == he_plus1) begin
                    n_nal_fu[7:0] = b;
                end
            end
        end
    end

    assign o_view.flags      = n_flags;
    assign o_view.marker_pt  = n_marker_pt;
    assign o_view.seq        = n_seq;
    assign o_view.ts         = n_ts;
    assign o_view.ssrc       = n_ssrc;
    assign o_view.header_end = n_header_end;
    assign o_view.nal_fu     = n_nal_fu;
    assign o_view.count      = n_pos;
    assign o_view.too_long   = n_too_long;

    // packet state registers; the final byte returns them to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_byte.last)) begin
            r_pos        <= '0;
            r_flags      <= '0;
            r_marker_pt  <= '0;
            r_seq        <= '0;
            r_ts         <= '0;
            r_ssrc       <= '0;
            r_ext        <= '0;
            r_header_end <= HDR_END_RESET;
            r_nal_fu     <= '0;
            r_too_long   <= 1'b0;
        end else if (i_step) begin
            r_pos        <= n_pos;
            r_flags      <= n_flags;
            r_marker_pt  <= n_marker_pt;
            r_seq        <= n_seq;
            r_ts         <= n_ts;
            r_ssrc       <= n_ssrc;
            r_ext        <= n_ext;
            r_header_end <= n_header_end;
            r_nal_fu     <= n_nal_fu;
            r_too_long   <= n_too_long;
        end
    end

    // header end never falls below the fixed header
    a_hdr_end_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_end >= HDR_END_RESET)
        else $error("header end below fixed header length");

    // overflow flag only once the byte count is saturated
    a_too_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> r_pos == POS_W'(MAX_PACKET_BYTES))
        else $error("too long flag set before packet limit");

endmodule

`default_nettype wire

[design/rhp_classify.sv]
// ----------------------------------------------------------------------------
// rhp_classify
// Payload bounds and H.264 classification of a finished packet, held in
// the result register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_classify (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic [7:0]         i_last_data,
    input  wire rhp_pkg::t_pkt_view i_view,
    output logic                    o_res_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [3:0]              o_status,
    output logic [1:0]              o_rtp_version,
    output logic                    o_marker_bit,
    output logic [6:0]              o_payload_kind,
    output logic [15:0]             o_seq_num,
    output logic [31:0]             o_rtp_timestamp,
    output logic [31:0]             o_source_id,
    output logic [4:0]              o_nal_type,
    output logic [7:0]              o_nal_header_byte,
    output logic                    o_nal_header_valid,
    output logic [15:0]             o_data_offset,
    output logic [15:0]             o_data_length
);
    import rhp_pkg::*;

    logic        r_out_valid;
    t_status     r_status;
    logic [1:0]  r_version;
    logic [7:0]  r_marker_pt;
    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic [31:0] r_ssrc;
    logic [4:0]  r_nal_type;
    logic [7:0]  r_nhb;
    logic        r_nvalid;
    logic [15:0] r_off;
    logic [15:0] r_len;

    t_status     n_status;
    logic [4:0]  n_nal_type;
    logic [7:0]  n_nhb;
    logic        n_nvalid;
    logic [15:0] n_off;
    logic [15:0] n_len;

    logic [7:0]  pad;
    logic [19:0] rem;
    logic [15:0] plen;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [4:0]  t;

    // bytes left for the NAL payload after header and padding
    always_comb begin
        pad  = i_view.flags[5] ? i_last_data : 8'd0;
        rem  = 20'(i_view.count) - 20'(pad) - 20'(i_view.header_end);
        plen = rem[15:0];
        b0   = i_view.nal_fu[15:8];
        b1   = i_view.nal_fu[7:0];
        t    = b0[4:0];
    end

    // status and NAL fields
    always_comb begin
        n_status   = ST_OK;
        n_nal_type = '0;
        n_nhb      = '0;
        n_nvalid   = 1'b0;
        n_off      = '0;
        n_len      = '0;
        if (i_view.too_long) begin
            n_status = ST_TOO_LONG;
        end else if (i_view.count < FIXED_HDR_BYTES) begin
            n_status = ST_SHORT;
        end else if (rem[19]) begin
            n_status = ST_OVERRUN;
        end else if (rem == '0) begin
            n_status = ST_EMPTY;
        end else if (b0[7]) begin
            n_status = ST_FORBIDDEN;
        end else begin
            case (t) inside
                [NAL_SINGLE_FIRST:NAL_SINGLE_LAST]: begin
                    n_nal_type = t;
                    n_nhb      = b0;
                    n_nvalid   = 1'b1;
                    n_off      = i_view.header_end[15:0] + 16'd1;
                    n_len      = plen - 16'd1;
                end
                NAL_FU_A: begin
                    if (plen < 16'd2) begin
                        n_status = ST_SHORT;
                    end else begin
                        n_nal_type = b1[4:0];
                        n_nhb      = {b0[7:5], b1[4:0]};
                        n_nvalid   = b1[7];
                        n_off      = i_view.header_end[15:0] + 16'd2;
                        n_len      = plen - 16'd2;
                    end
                end
                NAL_STAP_A: n_status = ST_STAP_A;
                NAL_STAP_B: n_status = ST_STAP_B;
                NAL_MTAP16: n_status = ST_MTAP16;
                NAL_MTAP24: n_status = ST_MTAP24;
                NAL_FU_B:   n_status = ST_FU_B;
                default:    n_status = ST_UNKNOWN;
            endcase
        end
    end

    assign o_res_ready = !r_out_valid || i_out_ready;

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status    <= n_status;
            r_version   <= i_view.flags[7:6];
            r_marker_pt <= i_view.marker_pt;
            r_seq       <= i_view.seq;
            r_ts        <= i_view.ts;
            r_ssrc      <= i_view.ssrc;
            r_nal_type  <= n_nal_type;
            r_nhb       <= n_nhb;
            r_nvalid    <= n_nvalid;
            r_off       <= n_off;
            r_len       <= n_len;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_rtp_version      = r_version;
    assign o_marker_bit       = r_marker_pt[7];
    assign o_payload_kind     = r_marker_pt[6:0];
    assign o_seq_num          = r_seq;
    assign o_rtp_timestamp    = r_ts;
    assign o_source_id        = r_ssrc;
    assign o_nal_type         = r_nal_type;
    assign o_nal_header_byte  = r_nhb;
    assign o_nal_header_valid = r_nvalid;
    assign o_data_offset      = r_off;
    assign o_data_length      = r_len;

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_res_ready)
        else $error("result register overwritten");

    // error results carry no NAL bounds
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |->
            (!r_nvalid && r_off == '0 && r_len == '0 && r_nal_type == '0))
        else $error("NAL fields set on error status");

endmodule

`default_nettype wire

[design/rtp_h264_header_parser.sv]
// ----------------------------------------------------------------------------
// rtp_h264_header_parser
// RTP header parser with H.264 (RFC 3984) payload classification.
//
// Input channel (i_in_valid / o_in_ready) carries one packet byte per
// transfer, with i_last_byte high on the final byte. Output channel
// (o_out_valid / i_out_ready) carries one result per packet: header fields,
// status, NAL header byte and the offset and length of the NAL data.
// Throughput is one byte per cycle, except that a final byte waits while
// the result register still holds an untaken result. The final byte passes
// through the input register and then the result register, which raises
// o_out_valid; the state update and the classification are a single
// combinational pass between these two registers.
// When the receiver stalls, the finished result waits in the result
// register and non-final bytes keep flowing; only a second final byte
// waits, in the input register, until the held result is taken.
// Reset (synchronous, active low) empties both registers and returns the
// packet state to the start of a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_h264_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic [1:0]       o_rtp_version,
    output logic             o_marker_bit,
    output logic [6:0]       o_payload_kind,
    output logic [15:0]      o_seq_num,
    output logic [31:0]      o_rtp_timestamp,
    output logic [31:0]      o_source_id,
    output logic [4:0]       o_nal_type,
    output logic [7:0]       o_nal_header_byte,
    output logic             o_nal_header_valid,
    output logic [15:0]      o_data_offset,
    output logic [15:0]      o_data_length
);
    import rhp_pkg::*;

    t_byte_xfer in_byte;
    t_byte_xfer cur_byte;
    t_pkt_view  view;
    logic       step;
    logic       res_ready;

    assign in_byte.data = i_data_byte;
    assign in_byte.last = i_last_byte;

    // input register
    rhp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_byte      (in_byte),
        .i_res_ready (res_ready),
        .o_step      (step),
        .o_byte      (cur_byte)
    );

    // packet state
    rhp_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (cur_byte),
        .o_view  (view)
    );

    // classification and result register
    rhp_classify u_classify (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (step && cur_byte.last),
        .i_last_data        (cur_byte.data),
        .i_view             (view),
        .o_res_ready        (res_ready),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_rtp_version      (o_rtp_version),
        .o_marker_bit       (o_marker_bit),
        .o_payload_kind     (o_payload_kind),
        .o_seq_num          (o_seq_num),
        .o_rtp_timestamp    (o_rtp_timestamp),
        .o_source_id        (o_source_id),
        .o_nal_type         (o_nal_type),
        .o_nal_header_byte  (o_nal_header_byte),
        .o_nal_header_valid (o_nal_header_valid),
        .o_data_offset      (o_data_offset),
        .o_data_length      (o_data_length)
    );

endmodule

`default_nettype wire

[bench/rtp_h264_header_parser_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_h264_header_parser_test
// Self-checking bench for the RTP / H.264 header parser. Packets are built
// byte by byte (directed corner cases, then random well-formed, truncated
// and noise packets) and streamed through the input channel with random
// bursts and gaps. A scoreboard class tracks the packet state as each byte
// transfer is accepted, predicts the result that the final byte produces,
// and checks every output transfer field by field.
// ----------------------------------------------------------------------------

module rtp_h264_header_parser_test;

    import rhp_pkg::*;

    localparam int RANDOM_BYTES   = 1080;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    // one parse result as seen on the output channel
    typedef struct packed {
        t_status     status;
        logic [1:0]  version;
        logic        marker;
        logic [6:0]  kind;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [4:0]  nal_type;
        logic [7:0]  nal_hdr;
        logic        nal_valid;
        logic [15:0] offset;
        logic [15:0] length;
    } parse_result;

    // tracks packet state per accepted byte and holds the predicted results
    class header_scoreboard;
        int unsigned  pos;
        logic [63:0]  hdr_word;
        logic [31:0]  ssrc_word;
        logic [7:0]   flags;
        logic [15:0]  ext_words;
        int unsigned  hdr_end;
        logic [7:0]   nal_b0;
        logic [7:0]   nal_b1;
        bit           too_long;
        parse_result  pending_results[$];
        int           errors;

        function new();
            errors = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            pos       = 0;
            hdr_word  = '0;
            ssrc_word = '0;
            flags     = '0;
            ext_words = '0;
            hdr_end   = 12;
            nal_b0    = '0;
            nal_b1    = '0;
            too_long  = 0;
        endfunction

        // capture one byte at position p of the packet
        function void take_byte(int unsigned p, logic [7:0] d);
            int unsigned base;
            int unsigned ext_end;
            if (p == 0) begin
                flags     = d;
                hdr_word  = '0;
                ssrc_word = '0;
                ext_words = '0;
                nal_b0    = '0;
                nal_b1    = '0;
            end else if (p < 8) begin
                hdr_word[(7 - p) * 8 +: 8] = d;
            end else if (p < 12) begin
                ssrc_word[(11 - p) * 8 +: 8] = d;
            end
            base = 12 + 4 * flags[3:0];
            if (p == 0)
                hdr_end = base + (flags[4] ? 4 : 0);
            // extension length word sits after the 16-bit profile
            if (flags[4] && (p == base + 2 || p == base + 3)) begin
                ext_words = {ext_words[7:0], d};
                if (p == base + 3) begin
                    ext_end = base + 4 + 4 * ext_words;
                    hdr_end = (ext_end > int'(HDR_END_MAX)) ? int'(HDR_END_MAX) : ext_end;
                end
            end
            if (p >= 12 && p == hdr_end)
                nal_b0 = d;
            else if (p >= 12 && p == hdr_end + 1)
                nal_b1 = d;
        endfunction

        // note an accepted input transfer; a final byte yields a result
        function void note_byte(logic [7:0] d, logic last);
            int unsigned n;
            int unsigned pad;
            int unsigned plen;
            longint      avail;
            logic [4:0]  t;
            parse_result r;
            if (pos >= MAX_PACKET_BYTES) begin
                too_long = 1;
            end else begin
                take_byte(pos, d);
                pos++;
            end
            if (!last)
                return;

            n     = pos;
            pad   = flags[5] ? d : 0;
            avail = longint'(n) - longint'(pad);
            t     = nal_b0[4:0];

            r           = '0;
            r.status    = ST_OK;
            r.version   = flags[7:6];
            r.marker    = hdr_word[55];
            r.kind      = hdr_word[54:48];
            r.seq       = hdr_word[47:32];
            r.ts        = hdr_word[31:0];
            r.ssrc      = ssrc_word;

            if (too_long) begin
                r.status = ST_TOO_LONG;
            end else if (n < 12) begin
                r.status = ST_SHORT;
            end else if (longint'(hdr_end) > avail) begin
                r.status = ST_OVERRUN;
            end else if (longint'(hdr_end) == avail) begin
                r.status = ST_EMPTY;
            end else if (nal_b0[7]) begin
                r.status = ST_FORBIDDEN;
            end else begin
                plen = 32'(avail - longint'(hdr_end));
                case (t)
                    NAL_FU_A: begin
                        // fu-a needs its fu header byte as well
                        if (plen < 2) begin
                            r.status = ST_SHORT;
                        end else begin
                            r.nal_type  = nal_b1[4:0];
                            r.nal_hdr   = {nal_b0[7:5], nal_b1[4:0]};
                            r.nal_valid = nal_b1[7];
                            r.offset    = 16'(hdr_end + 2);
                            r.length    = 16'(plen - 2);
                        end
                    end
                    NAL_STAP_A: r.status = ST_STAP_A;
                    NAL_STAP_B: r.status = ST_STAP_B;
                    NAL_MTAP16: r.status = ST_MTAP16;
                    NAL_MTAP24: r.status = ST_MTAP24;
                    NAL_FU_B:   r.status = ST_FU_B;
                    default: begin
                        if (t >= NAL_SINGLE_FIRST && t <= NAL_SINGLE_LAST) begin
                            r.nal_type  = t;
                            r.nal_hdr   = nal_b0;
                            r.nal_valid = 1'b1;
                            r.offset    = 16'(hdr_end + 1);
                            r.length    = 16'(plen - 1);
                        end else begin
                            r.status = ST_UNKNOWN;
                        end
                    end
                endcase
            end
            pending_results.push_back(r);
            clear_packet();
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned seen);
            if (want != seen) begin
                errors++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, seen);
            end
        endfunction

        // check one output transfer against the oldest prediction
        function void check_result(parse_result seen);
            parse_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual status %0d",
                         $time, seen.status);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status",           want.status,    seen.status);
            compare_field("rtp_version",      want.version,   seen.version);
            compare_field("marker_bit",       want.marker,    seen.marker);
            compare_field("payload_kind",     want.kind,      seen.kind);
            compare_field("seq_num",          want.seq,       seen.seq);
            compare_field("rtp_timestamp",    want.ts,        seen.ts);
            compare_field("source_id",        want.ssrc,      seen.ssrc);
            compare_field("nal_type",         want.nal_type,  seen.nal_type);
            compare_field("nal_header_byte",  want.nal_hdr,   seen.nal_hdr);
            compare_field("nal_header_valid", want.nal_valid, seen.nal_valid);
            compare_field("data_offset",      want.offset,    seen.offset);
            compare_field("data_length",      want.length,    seen.length);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_status;
    logic [1:0]  o_rtp_version;
    logic        o_marker_bit;
    logic [6:0]  o_payload_kind;
    logic [15:0] o_seq_num;
    logic [31:0] o_rtp_timestamp;
    logic [31:0] o_source_id;
    logic [4:0]  o_nal_type;
    logic [7:0]  o_nal_header_byte;
    logic        o_nal_header_valid;
    logic [15:0] o_data_offset;
    logic [15:0] o_data_length;

    header_scoreboard sb;
    parse_result      seen_result;
    logic [7:0]       pkt[$];
    int               bytes_taken   = 0;
    int               burst_left    = 0;
    bit               gaps_on       = 1;
    int               hold_requests = 0;
    int               holds_done    = 0;
    int               idle_cycles   = 0;

    rtp_h264_header_parser i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_rtp_version      (o_rtp_version),
        .o_marker_bit       (o_marker_bit),
        .o_payload_kind     (o_payload_kind),
        .o_seq_num          (o_seq_num),
        .o_rtp_timestamp    (o_rtp_timestamp),
        .o_source_id        (o_source_id),
        .o_nal_type         (o_nal_type),
        .o_nal_header_byte  (o_nal_header_byte),
        .o_nal_header_valid (o_nal_header_valid),
        .o_data_offset      (o_data_offset),
        .o_data_length      (o_data_length)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // check every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_result.status    = t_status'(o_status);
            seen_result.version   = o_rtp_version;
            seen_result.marker    = o_marker_bit;
            seen_result.kind      = o_payload_kind;
            seen_result.seq       = o_seq_num;
            seen_result.ts        = o_rtp_timestamp;
            seen_result.ssrc      = o_source_id;
            seen_result.nal_type  = o_nal_type;
            seen_result.nal_hdr   = o_nal_header_byte;
            seen_result.nal_valid = o_nal_header_valid;
            seen_result.offset    = o_data_offset;
            seen_result.length    = o_data_length;
            sb.check_result(seen_result);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
            $display("rtp_h264_header_parser_test: errors");
            $finish;
        end
    end

    // receiver: rotating stall pattern, plus long hold-offs on request
    initial begin : receiver
        logic [15:0] pattern;
        int          pattern_left;
        int          hold_left;
        pattern      = '1;
        pattern_left = 0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = 16'($urandom) | 16'h0001;
                    pattern_left = $urandom_range(16, 128);
                    if ($urandom_range(0, 3) == 0)
                        pattern = '1;
                end
                i_out_ready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
                pattern_left--;
            end
        end
    end

    // build an rtp packet; fill 0 random, 1 all zeros, 2 all ones
    task automatic make_rtp(logic [1:0] ver, int fill, logic [3:0] cc, logic x,
                            logic [15:0] ext_words, logic pflag, logic [7:0] pad_count,
                            logic [7:0] nal0, logic [7:0] nal1, int pay_len);
        int k;
        pkt.delete();
        pkt.push_back({ver, pflag, x, cc});
        for (k = 1; k < 12; k++)
            pkt.push_back(fill == 1 ? 8'h00 : fill == 2 ? 8'hFF : 8'($urandom));
        for (k = 0; k < 4 * cc; k++)
            pkt.push_back(8'($urandom));
        if (x) begin
            pkt.push_back(8'($urandom));
            pkt.push_back(8'($urandom));
            pkt.push_back(ext_words[15:8]);
            pkt.push_back(ext_words[7:0]);
            // long extensions are left without body, which overruns
            if (ext_words <= 1024)
                for (k = 0; k < 4 * ext_words; k++)
                    pkt.push_back(8'($urandom));
        end
        for (k = 0; k < pay_len; k++)
            pkt.push_back(k == 0 ? nal0 : k == 1 ? nal1 : 8'($urandom));
        if (pflag) begin
            for (k = 1; k < pad_count; k++)
                pkt.push_back(8'($urandom));
            pkt.push_back(pad_count);
        end
    endtask

    task automatic make_noise(int len);
        int k;
        pkt.delete();
        for (k = 0; k < len; k++)
            pkt.push_back(8'($urandom));
    endtask

    // random packet: mostly well formed, some truncated, some noise
    task automatic make_random_packet();
        int          sel;
        int          cut;
        logic [4:0]  ntype;
        logic [1:0]  ver;
        logic [3:0]  cc;
        logic        x;
        logic        pflag;
        logic [15:0] ext_words;
        logic [7:0]  pad_count;
        sel = $urandom_range(0, 99);
        if (sel >= 88) begin
            make_noise($urandom_range(1, 40));
            return;
        end
        ver       = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'd2;
        cc        = ($urandom_range(0, 3) != 0) ? 4'd0 : 4'($urandom);
        x         = ($urandom_range(0, 2) == 0);
        ext_words = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        pflag     = ($urandom_range(0, 3) == 0);
        pad_count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        case ($urandom_range(0, 7))
            0, 1, 2, 3: ntype = 5'($urandom_range(1, 23));
            4, 5:       ntype = NAL_FU_A;
            default:    ntype = 5'($urandom);
        endcase
        make_rtp(ver, 0, cc, x, ext_words, pflag, pad_count,
                 {($urandom_range(0, 15) == 0), 2'($urandom), ntype},
                 8'($urandom), $urandom_range(0, 24));
        if (sel >= 75) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
    endtask

    // stream pkt through the input channel, in bursts with gaps
    task automatic send_packet();
        int k;
        int gap;
        for (k = 0; k < pkt.size(); k++) begin
            if (gaps_on && burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24)
                                                  : $urandom_range(1, 4);
                burst_left = $urandom_range(1, 48);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            if (burst_left > 0)
                burst_left--;
            i_in_valid  <= 1'b1;
            i_data_byte <= pkt[k];
            i_last_byte <= (k == pkt.size() - 1);
            @(posedge i_clk);
            while (!o_in_ready)
                @(posedge i_clk);
            sb.note_byte(pkt[k], k == pkt.size() - 1);
            bytes_taken++;
        end
    endtask

    // hold the input until every predicted result has been taken
    task automatic pause_for_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        logic [7:0] kinds[11];
        int         k;
        kinds = '{8'h00, 8'h65, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B,
                  8'h1D, 8'h1E, 8'h1F, 8'h85};
        // all-zero and all-one header fields
        make_rtp(2'd0, 1, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h01, 8'h00, 1);
        send_packet();
        make_rtp(2'd3, 2, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h77, 8'h00, 6);
        send_packet();
        // every nal type class but fu-a, forbidden bit last
        for (k = 0; k < 11; k++) begin
            make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, kinds[k], 8'($urandom), 4);
            send_packet();
        end
        // fu-a start, middle, end, bare fu header, missing fu header
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h7C, 8'h85, 6);
        send_packet();
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h5C, 8'h05, 6);
        send_packet();
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h3C, 8'h45, 6);
        send_packet();
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h7C, 8'h9F, 2);
        send_packet();
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h7C, 8'h00, 1);
        send_packet();
        // header only, and header plus padding that fills the packet
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h00, 8'h00, 0);
        send_packet();
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b1, 8'd4, 8'h00, 8'h00, 0);
        send_packet();
        // padding flag with a zero count
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b1, 8'd0, 8'h41, 8'h00, 3);
        send_packet();
        // full csrc list, extension and padding together
        make_rtp(2'd2, 0, 4'd15, 1'b1, 16'd2, 1'b1, 8'd3, 8'h67, 8'h00, 9);
        send_packet();
        // long extension body gives an offset past one byte
        make_rtp(2'd2, 0, 4'd1, 1'b1, 16'd70, 1'b0, 8'd0, 8'h61, 8'h00, 5);
        send_packet();
        // extension end past the packet, and past the header_end range
        make_rtp(2'd2, 0, 4'd1, 1'b1, 16'd2000, 1'b0, 8'd0, 8'h41, 8'h00, 4);
        send_packet();
        make_rtp(2'd2, 0, 4'd15, 1'b1, 16'hFFFF, 1'b0, 8'd0, 8'h41, 8'h00, 4);
        send_packet();
        // padding count larger than the packet
        make_rtp(2'd2, 0, 4'd0, 1'b0, 16'd0, 1'b0, 8'd0, 8'h41, 8'h00, 3);
        pkt[0] = pkt[0] | 8'h20;
        pkt[pkt.size() - 1] = 8'hF0;
        send_packet();
        // short packets
        make_noise(1);
        send_packet();
        make_noise(11);
        send_packet();
    endtask

    initial begin : stimulus
        int packets;
        int random_start;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        pause_for_results();

        // random traffic
        packets      = 0;
        random_start = bytes_taken;
        while (bytes_taken - random_start < RANDOM_BYTES) begin
            if (packets % 20 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (packets == 15)
                hold_requests++;
            if (packets == 40 || packets == 70)
                pause_for_results();
            make_random_packet();
            send_packet();
            packets++;
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("rtp_h264_header_parser_test: clean");
        else
            $display("rtp_h264_header_parser_test: errors");
        $finish;
    end

endmodule
